// ----- rtl/rbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the RGB 3x3 box blur: pixel and column-sum
// records, register codes and the fixed-point reciprocal of nine.
// ----------------------------------------------------------------------------
package rbb_pkg;

   localparam int CHAN_W           = 8;    // bits per color channel
   localparam int CFG_W            = 9;    // bits of a size register
   localparam int COLSUM_W         = 10;   // sum of three channel values
   localparam int WINSUM_W         = 12;   // sum of nine channel values
   localparam int RECIP_W          = 13;
   localparam int RECIP_SHIFT      = 16;
   localparam int PROD_W           = WINSUM_W + RECIP_W;
   localparam int DEF_MAX_COLUMNS  = 256;
   localparam int DEF_MAX_ROWS     = 256;
   localparam int MIN_SIZE         = 3;

   // ceil(2^16 / 9): exact floor division for any nine-pixel sum
   localparam logic [RECIP_W-1:0] RECIP_NINE   = 13'd7282;
   localparam logic [CFG_W-1:0]   SIZE_RESET   = 9'd256;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // one column entry of the paired line store: rows i-2 and i-1
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef struct packed {
      logic [COLSUM_W-1:0] red;
      logic [COLSUM_W-1:0] green;
      logic [COLSUM_W-1:0] blue;
   } colsum_type;

endpackage

// ----- rtl/rbb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_if
// Valid/ready channels of the box blur: incoming pixels and filtered results.
// ----------------------------------------------------------------------------
interface rbb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   output ready);
endinterface

interface rbb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       frame_last;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output frame_last, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input frame_last, output ready);
endinterface

// ----- rtl/rgb_box_blur_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_unit
// 3x3 mean filter on a raster-order RGB stream, 8 bits per channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one pixel per transaction in raster order; rsp_if carries
//   the truncated mean of the 3x3 neighbourhood of every interior pixel,
//   with frame_last set on the last interior result of a frame. Border
//   pixels produce no transaction.
//   The APB port holds image_width (0x0) and image_height (0x4); sizes below
//   3 act as 3, sizes above the maximum act as the maximum. Any write to a
//   size register restarts the frame at row 0, column 0.
//   Throughput is one pixel per cycle unless the receiver stalls. A result
//   for centre (i-1,j-1) follows the transaction of pixel (i,j) that
//   completes its window through line-store read at the transaction edge,
//   column-cell shift, window sum, reciprocal multiply into the output register.
//   When the receiver stalls, the whole pipeline holds and req_if.ready
//   drops only while a finished result waits in the output register.
//   Synchronous reset empties the pipeline, clears the window cells and the
//   position counters and sets both sizes to 256. Line stores need no
//   clearing: every result reads only columns written in the current frame.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_unit
   import rbb_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   rbb_req_if.sink     req_if,
   rbb_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW   = $clog2(MAX_COLUMNS);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CWE  = $clog2(MAX_COLUMNS + 1);
   localparam int RWE  = $clog2(MAX_ROWS + 1);
   localparam int WEW  = (CWE > CFG_W) ? CWE : CFG_W;
   localparam int HEW  = (RWE > CFG_W) ? RWE : CFG_W;

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic             csr_wr;
   csr_reg_type      csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_IMAGE_WIDTH:  prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: prdata = 32'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // Clamp the frame size to the supported range.
   logic [WEW-1:0] w_eff;
   logic [HEW-1:0] h_eff;

   always_comb begin
      priority if (WEW'(width_ff) < WEW'(MIN_SIZE)) begin
         w_eff = WEW'(MIN_SIZE);
      end else if (WEW'(width_ff) > WEW'(MAX_COLUMNS)) begin
         w_eff = WEW'(MAX_COLUMNS);
      end else begin
         w_eff = WEW'(width_ff);
      end
      priority if (HEW'(height_ff) < HEW'(MIN_SIZE)) begin
         h_eff = HEW'(MIN_SIZE);
      end else if (HEW'(height_ff) > HEW'(MAX_ROWS)) begin
         h_eff = HEW'(MAX_ROWS);
      end else begin
         h_eff = HEW'(height_ff);
      end
   end

   // ---------------------------------------------------------- handshake
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   // Advance every stage unless a finished result is held by the receiver.
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign accept       = req_if.valid && advance;

   // ------------------------------------------------------ position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic          restart;
   logic          cur_emit;
   logic          cur_last;

   always_comb begin
      // Restart the frame when a size change left the position outside it.
      restart  = (WEW'(col_ff) >= w_eff) || (HEW'(row_ff) >= h_eff);
      cur_col  = restart ? '0 : col_ff;
      cur_row  = restart ? '0 : row_ff;
      cur_emit = (CWE'(cur_col) >= CWE'(2)) && (RWE'(cur_row) >= RWE'(2));
      cur_last = (WEW'(cur_col) == w_eff - WEW'(1)) && (HEW'(cur_row) == h_eff - HEW'(1));
      col_in   = col_ff;
      row_in   = row_ff;
      priority if (csr_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (WEW'(cur_col) + WEW'(1) >= w_eff) begin
            col_in = '0;
            row_in = (HEW'(cur_row) + HEW'(1) >= h_eff) ? '0 : cur_row + RW'(1);
         end else begin
            col_in = cur_col + CW'(1);
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------- stage 1: line-store read
   logic          s1_valid_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic [CW-1:0] s1_col_ff;
   pixel_type     s1_px_ff;
   line_pair_type rd_pair;
   line_pair_type wr_pair;
   logic          s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= cur_emit;
         s1_last_ff     <= cur_last;
         s1_col_ff      <= cur_col;
         s1_px_ff.red   <= req_if.in_red;
         s1_px_ff.green <= req_if.in_green;
         s1_px_ff.blue  <= req_if.in_blue;
      end
   end

   // Shift the middle row up and store the new pixel as the middle row.
   assign s1_fire        = s1_valid_ff && advance;
   assign wr_pair.upper  = rd_pair.middle;
   assign wr_pair.middle = s1_px_ff;

   rbb_line_store #(
      .DEPTH   (MAX_COLUMNS)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_pair),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (wr_pair)
   );

   // ------------------------------------ stage 2: window as a chain of cells
   colsum_type new_col;
   colsum_type chain [4];

   always_comb begin
      new_col.red   = COLSUM_W'(rd_pair.upper.red) + COLSUM_W'(rd_pair.middle.red)
                    + COLSUM_W'(s1_px_ff.red);
      new_col.green = COLSUM_W'(rd_pair.upper.green) + COLSUM_W'(rd_pair.middle.green)
                    + COLSUM_W'(s1_px_ff.green);
      new_col.blue  = COLSUM_W'(rd_pair.upper.blue) + COLSUM_W'(rd_pair.middle.blue)
                    + COLSUM_W'(s1_px_ff.blue);
   end

   assign chain[0] = new_col;

   // Cell 0 holds the newest column, cell 2 the oldest.
   for (genvar g = 0; g < 3; g++) begin : g_cell
      rbb_column_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_fire),
         .col_in   (chain[g]),
         .col_out  (chain[g+1])
      );
   end

   logic s2_valid_ff;
   logic s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   // ------------------------------------------------- stage 3: window sum
   logic                s3_valid_ff;
   logic                s3_last_ff;
   logic [WINSUM_W-1:0] s3_red_ff, s3_green_ff, s3_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_last_ff  <= s2_last_ff;
         s3_red_ff   <= WINSUM_W'(chain[1].red) + WINSUM_W'(chain[2].red)
                      + WINSUM_W'(chain[3].red);
         s3_green_ff <= WINSUM_W'(chain[1].green) + WINSUM_W'(chain[2].green)
                      + WINSUM_W'(chain[3].green);
         s3_blue_ff  <= WINSUM_W'(chain[1].blue) + WINSUM_W'(chain[2].blue)
                      + WINSUM_W'(chain[3].blue);
      end
   end

   // -------------------------------- output register: divide by nine
   logic [PROD_W-1:0] prod_red, prod_green, prod_blue;
   logic [7:0]        rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic              rsp_last_ff;

   // floor(x / 9) = (x * ceil(2^16 / 9)) >> 16 for every window sum
   assign prod_red   = PROD_W'(s3_red_ff) * PROD_W'(RECIP_NINE);
   assign prod_green = PROD_W'(s3_green_ff) * PROD_W'(RECIP_NINE);
   assign prod_blue  = PROD_W'(s3_blue_ff) * PROD_W'(RECIP_NINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_red_ff   <= prod_red[RECIP_SHIFT +: CHAN_W];
         rsp_green_ff <= prod_green[RECIP_SHIFT +: CHAN_W];
         rsp_blue_ff  <= prod_blue[RECIP_SHIFT +: CHAN_W];
         rsp_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_red    = rsp_red_ff;
   assign rsp_if.out_green  = rsp_green_ff;
   assign rsp_if.out_blue   = rsp_blue_ff;
   assign rsp_if.frame_last = rsp_last_ff;

endmodule

// ----- rtl/rbb_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_line_store
// Paired line memory: one entry per column holds the two previous rows.
// One registered read port, one write port.
// ----------------------------------------------------------------------------
module rbb_line_store
   import rbb_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_COLUMNS
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output line_pair_type            rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  line_pair_type            wr_data
);

   line_pair_type mem_ff [DEPTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rbb_column_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_column_cell
// One window column: holds the per-channel sum of three stacked pixels and
// hands it to the next cell on every shift.
// ----------------------------------------------------------------------------
module rbb_column_cell
   import rbb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  colsum_type col_in,
   output colsum_type col_out
);

   colsum_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB 3x3 box blur. Frames of random and
// extreme pixels stream in under several frame sizes, including sizes that
// must be clamped. A built-in line-buffer model predicts every filtered
// pixel, and each result transaction is checked field by field against the
// oldest prediction, with random gaps on both channels and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import rbb_pkg::*;

   localparam int MAX_COLS     = DEF_MAX_COLUMNS;
   localparam int MAX_LINES    = DEF_MAX_ROWS;
   localparam int DRAIN_CYCLES = 12;      // pipeline is four deep, keep some slack
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int CYCLE_LIMIT  = 100000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      pixel_type mean;
      logic      last;
   } blur_result_type;

   // clock, reset and configuration port
   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rbb_req_if pixel_ch ();
   rbb_rsp_if blur_ch ();

   // pending stimulus and predicted results
   pixel_type       pixel_q [$];
   blur_result_type blur_expect_q [$];

   // filter model state
   pixel_type       upper_row [MAX_COLS];
   pixel_type       middle_row [MAX_COLS];
   pixel_type       window_px [9];
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int unsigned     col_pos;
   int unsigned     row_pos;

   // run control and statistics
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   logic        hold_off;
   bit          pressure_go;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned pixels_accepted;
   int unsigned results_checked;
   int unsigned frames_done;
   int unsigned size_writes;

   rgb_box_blur_3x3_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (pixel_ch),
      .rsp_if  (blur_ch),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Filter model
   // ------------------------------------------------------------------------

   // Size registers act within 3..max; anything outside is pulled to the edge.
   function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
      if (32'(v) < MIN_SIZE) return MIN_SIZE;
      if (32'(v) > hi) return hi;
      return 32'(v);
   endfunction

   // Any size write restarts the frame at row 0, column 0.
   task automatic blur_apply_size(csr_reg_type sel, logic [31:0] value);
      if (sel == REG_IMAGE_WIDTH) begin
         width_reg = value[CFG_W-1:0];
      end else begin
         height_reg = value[CFG_W-1:0];
      end
      col_pos = 0;
      row_pos = 0;
   endtask

   // Advance the model by one accepted pixel; queue a result for interior
   // centres, i.e. once the window spans three rows and three columns.
   task automatic blur_predict(pixel_type px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     i;
      int unsigned     j;
      int unsigned     sr;
      int unsigned     sg;
      int unsigned     sb;
      int              k;
      pixel_type       up;
      pixel_type       mid;
      blur_result_type res;
      w = clamp_size(width_reg, MAX_COLS);
      h = clamp_size(height_reg, MAX_LINES);
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      j = col_pos;
      i = row_pos;
      up  = upper_row[j];
      mid = middle_row[j];
      upper_row[j]  = mid;
      middle_row[j] = px;
      // shift the window left; column 2 takes the newest column
      for (k = 0; k < 3; k++) begin
         window_px[k*3]   = window_px[k*3+1];
         window_px[k*3+1] = window_px[k*3+2];
      end
      window_px[2] = up;
      window_px[5] = mid;
      window_px[8] = px;
      if (i >= 2 && j >= 2) begin
         sr = 0;
         sg = 0;
         sb = 0;
         for (k = 0; k < 9; k++) begin
            sr += window_px[k].red;
            sg += window_px[k].green;
            sb += window_px[k].blue;
         end
         res.mean.red   = 8'(sr / 9);
         res.mean.green = 8'(sg / 9);
         res.mean.blue  = 8'(sb / 9);
         res.last       = (i == h - 1 && j == w - 1);
         blur_expect_q.push_back(res);
      end
      if (j + 1 >= w) begin
         col_pos = 0;
         row_pos = (i + 1 >= h) ? 0 : i + 1;
      end else begin
         col_pos = j + 1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: offer queued pixels, hold each until its transaction completes
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type nxt;
      if (reset) begin
         pixel_ch.valid <= 1'b0;
      end else begin
         if (pixel_ch.valid && pixel_ch.ready) begin
            blur_predict(pixel_type'({pixel_ch.in_red, pixel_ch.in_green,
                                      pixel_ch.in_blue}));
            pixels_accepted++;
         end
         // the slot is free once the previous pixel is taken or none was offered
         if (!pixel_ch.valid || pixel_ch.ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pixel_q.pop_front();
               pixel_ch.valid    <= 1'b1;
               pixel_ch.in_red   <= nxt.red;
               pixel_ch.in_green <= nxt.green;
               pixel_ch.in_blue  <= nxt.blue;
            end else begin
               pixel_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each result transaction against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH at cycle %0d, result %0d: %s got %0d expected %0d",
               cycle_count, results_checked, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      blur_result_type want;
      if (reset) begin
         blur_ch.ready <= 1'b0;
      end else begin
         if (blur_ch.valid && blur_ch.ready) begin
            if (blur_expect_q.size() == 0) begin
               report_mismatch("unexpected result, pending count", 0, 0);
            end else begin
               want = blur_expect_q.pop_front();
               if (blur_ch.out_red !== want.mean.red)
                  report_mismatch("out_red", blur_ch.out_red, want.mean.red);
               if (blur_ch.out_green !== want.mean.green)
                  report_mismatch("out_green", blur_ch.out_green, want.mean.green);
               if (blur_ch.out_blue !== want.mean.blue)
                  report_mismatch("out_blue", blur_ch.out_blue, want.mean.blue);
               if (blur_ch.frame_last !== want.last)
                  report_mismatch("frame_last", blur_ch.frame_last, want.last);
            end
            if (blur_ch.frame_last === 1'b1) frames_done++;
            results_checked++;
         end
         blur_ch.ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: give up if the run stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles with %0d results outstanding",
                  cycle_count, blur_expect_q.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // Pressure: once armed, let the stream reach the last row of the wide
   // frame so results flow, then hold the output off for a long stretch so
   // the pipeline fills and the input stalls.
   initial begin
      hold_off = 1'b0;
      while (!pressure_go) @(negedge clock);
      repeat (600) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // APB write: setup cycle, then access cycle; the model follows at the
   // edge that commits the register.
   task automatic csr_write(csr_reg_type sel, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      blur_apply_size(sel, value);
      size_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_sizes(logic [31:0] w, logic [31:0] h);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      @(negedge clock);
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;  receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 56; receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;  receiver_stall_pct = 56;
         end
         default: begin
            sender_idle_pct = 9;  receiver_stall_pct = 9;
         end
      endcase
   endtask

   // Random channels, leaning toward the extremes now and then.
   function automatic logic [7:0] random_channel();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   task automatic push_random(int n);
      pixel_type px;
      repeat (n) begin
         px.red   = random_channel();
         px.green = random_channel();
         px.blue  = random_channel();
         pixel_q.push_back(px);
      end
   endtask

   // Wait for the stream to be taken and every predicted result to arrive,
   // then let trailing border pixels clear the pipeline.
   task automatic drain_pipeline();
      while (pixel_q.size() != 0 || pixel_ch.valid) @(negedge clock);
      while (blur_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int w;
      int h;
      int n;
      // every input known from time zero
      reset              = 1'b1;
      pixel_ch.valid     = 1'b0;
      pixel_ch.in_red    = '0;
      pixel_ch.in_green  = '0;
      pixel_ch.in_blue   = '0;
      blur_ch.ready      = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      pressure_go        = 1'b0;
      cycle_count        = 0;
      error_count        = 0;
      pixels_accepted    = 0;
      results_checked    = 0;
      frames_done        = 0;
      size_writes        = 0;
      width_reg          = SIZE_RESET;
      height_reg         = SIZE_RESET;
      col_pos            = 0;
      row_pos            = 0;
      for (int k = 0; k < 9; k++) window_px[k] = '0;
      set_idling(IDLE_NONE);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: smallest frame, all white (largest sum), then a second
      // frame straight after the wrap with red alternating 00/FF, green 0, blue a ramp.
      set_sizes(3, 3);
      repeat (9) pixel_q.push_back(pixel_type'({8'hFF, 8'hFF, 8'hFF}));
      for (int k = 0; k < 9; k++)
         pixel_q.push_back(pixel_type'({(k % 2) ? 8'hFF : 8'h00, 8'h00, 8'(k * 31)}));
      drain_pipeline();

      // Directed: sizes below the minimum act as 3.
      set_sizes(0, 1);
      push_random(9);
      drain_pipeline();

      // Widest frame (oversized width clamps to the maximum), with the long
      // output hold-off while the sender never idles.
      set_sizes(9'h1FF, 3);
      pressure_go = 1'b1;
      push_random(3 * MAX_COLS);
      drain_pipeline();

      // Tallest frame, cut short by the next size write.
      set_idling(IDLE_SENDER);
      set_sizes(3, 256);
      push_random(240);
      drain_pipeline();

      // Upper bits of the write data are dropped; height 2 acts as 3.
      set_idling(IDLE_RECEIVER);
      set_sizes(32'hABCD_E003, 2);
      push_random(20);
      drain_pipeline();

      // Small random frames: whole frames, runs across the wrap and
      // frames broken off by a size write, cycling through idling patterns.
      for (int p = 0; p < 8; p++) begin
         set_idling(idle_mode_type'(p % 4));
         w = $urandom_range(3, 14);
         h = $urandom_range(3, 7);
         n = w * h * $urandom_range(1, 2);
         if ($urandom_range(3) == 0) n += $urandom_range(1, 2 * w);
         set_sizes(w, h);
         push_random(n);
         drain_pipeline();
      end

      $display("Covered %0d pixels, %0d filtered results, %0d complete frames",
               pixels_accepted, results_checked, frames_done);
      $display("over %0d size writes (3 to 256, clamped values included), %0d errors",
               size_writes, error_count);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
